// File: src/aeat_pkg.sv
// ----------------------------------------------------------------------------
// aeat_pkg
// Shared codes, configuration layout and helpers for the axis event
// auto-repeat table.
// ----------------------------------------------------------------------------
`default_nettype none

package aeat_pkg;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_INVERT_MASK   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEADZONE      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEAN          = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_TICKS    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_TICKS  = 3'd4;

    // Q1.15 reset levels: 0.05 and 0.5 of full scale
    localparam logic [14:0] DEADZONE_RESET = 15'd1638;
    localparam logic [14:0] LEAN_RESET     = 15'd16384;
    localparam logic [15:0] HOLD_RESET     = 16'd500;
    localparam logic [15:0] REPEAT_RESET   = 16'd200;

    typedef struct packed {
        logic [15:0] invert_mask;
        logic [14:0] deadzone_level;
        logic [14:0] lean_level;
        logic [15:0] hold_ticks;
        logic [15:0] repeat_ticks;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } back_state_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

// File: src/aeat_front.sv
// ----------------------------------------------------------------------------
// aeat_front
// Accepts requests, conditions sample values (clamp, invert, deadzone) and
// pushes them into the request queue.
// ----------------------------------------------------------------------------
`default_nettype none

module aeat_front #(
    parameter int VALUE_BITS = 16
) (
    input  aeat_pkg::cfg_t                cfg,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    opcode,
    input  logic [3:0]                    axis,
    input  logic [3:0]                    device,
    input  logic signed [VALUE_BITS-1:0]  value,
    input  logic [15:0]                   elapsed,
    input  logic                          queue_full,
    output logic                          push,
    output logic [2*VALUE_BITS+25-1:0]    item
);
    import aeat_pkg::*;

    localparam int MW = VALUE_BITS - 1;
    localparam int LW = (MW > 15) ? MW : 15;
    localparam logic [VALUE_BITS-1:0] MOST_NEG  = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] CLAMP_NEG = {1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1};

    logic [VALUE_BITS-1:0] v_clamp;
    logic [VALUE_BITS-1:0] v_inv;
    logic [VALUE_BITS-1:0] v_abs;
    logic [MW-1:0]         mag;
    logic                  in_dz;
    logic [VALUE_BITS-1:0] v_out;
    logic [MW-1:0]         m_out;
    logic                  op_known;

    always_comb
    begin
        v_clamp = (value == MOST_NEG) ? CLAMP_NEG : value;
        v_inv   = cfg.invert_mask[axis] ? (~v_clamp + 1'b1) : v_clamp;
        v_abs   = v_inv[VALUE_BITS-1] ? (~v_inv + 1'b1) : v_inv;
        mag     = v_abs[MW-1:0];
        in_dz   = LW'(mag) < LW'(cfg.deadzone_level);
        v_out   = in_dz ? '0 : v_inv;
        m_out   = in_dz ? '0 : mag;
    end

    // unused opcode is accepted and dropped here
    assign op_known = (opcode == OP_SAMPLE) || (opcode == OP_TICK) || (opcode == OP_CLEAR);
    assign busy     = queue_full;
    assign push     = start && !queue_full && op_known;
    assign item     = {opcode, axis, device, v_out, m_out, elapsed};

endmodule

`default_nettype wire

// File: src/aeat_fifo.sv
// ----------------------------------------------------------------------------
// aeat_fifo
// Two-entry request queue between the front and the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module aeat_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: src/aeat_back.sv
// ----------------------------------------------------------------------------
// aeat_back
// Table engine: walks the key table one entry per cycle for lookups and
// tick expiry, updates entries and drives the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module aeat_back #(
    parameter int ENTRIES    = 32,
    parameter int VALUE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  aeat_pkg::cfg_t                cfg,
    input  logic                          item_valid,
    input  logic [2*VALUE_BITS+25-1:0]    item,
    output logic                          pop,
    output logic                          result_valid,
    output logic [3:0]                    out_axis,
    output logic [3:0]                    out_device,
    output logic signed [VALUE_BITS-1:0]  out_value,
    output logic                          bump,
    output logic                          is_repeat,
    output logic                          last
);
    import aeat_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int MW = VALUE_BITS - 1;
    localparam int LW = (MW > 15) ? MW : 15;

    // queue payload
    logic [1:0]            item_op;
    logic [3:0]            item_axis;
    logic [3:0]            item_device;
    logic [VALUE_BITS-1:0] item_value;
    logic [MW-1:0]         item_mag;
    logic [15:0]           item_elapsed;

    assign {item_op, item_axis, item_device, item_value, item_mag, item_elapsed} = item;

    // table storage
    logic [7:0]            key_mem [ENTRIES];
    logic [VALUE_BITS-1:0] cur_mem [ENTRIES];
    logic [31:0]           dl_mem  [ENTRIES];
    logic [7:0]            rd_key_reg;
    logic [VALUE_BITS-1:0] rd_cur_reg;
    logic [31:0]           rd_dl_reg;

    back_state_t           state_reg, state_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pidx_reg, pidx_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [31:0]           now_reg, now_next;
    logic [ENTRIES-1:0]    armed_reg, armed_next;
    logic                  is_tick_reg, is_tick_next;
    logic [3:0]            it_axis_reg, it_axis_next;
    logic [3:0]            it_device_reg, it_device_next;
    logic [VALUE_BITS-1:0] it_value_reg, it_value_next;
    logic [MW-1:0]         it_mag_reg, it_mag_next;

    // a repeat waits here until the next one (or the end of the walk) decides last
    logic                  hold_valid_reg, hold_valid_next;
    logic [3:0]            hold_axis_reg, hold_axis_next;
    logic [3:0]            hold_device_reg, hold_device_next;
    logic [VALUE_BITS-1:0] hold_value_reg, hold_value_next;

    logic                  res_valid_reg, res_valid_next;
    logic [3:0]            res_axis_reg, res_axis_next;
    logic [3:0]            res_device_reg, res_device_next;
    logic [VALUE_BITS-1:0] res_value_reg, res_value_next;
    logic                  res_bump_reg, res_bump_next;
    logic                  res_rep_reg, res_rep_next;
    logic                  res_last_reg, res_last_next;

    logic                  key_we, cur_we, dl_we;
    logic [AW-1:0]         wr_addr;
    logic [7:0]            key_wd;
    logic [31:0]           dl_wd;

    logic                  scan_issue;
    logic                  scan_done;
    logic                  key_hit;
    logic                  expired;
    logic [31:0]           rep_dl;
    logic [31:0]           hold_dl;
    logic [VALUE_BITS-1:0] old_abs;
    logic                  old_not_above;
    logic                  leaned;
    logic                  above;

    assign rep_dl     = sat_add(now_reg, cfg.repeat_ticks);
    assign hold_dl    = sat_add(now_reg, cfg.hold_ticks);
    assign scan_issue = (state_reg == ST_SCAN) && (idx_reg < count_reg);
    assign scan_done  = (state_reg == ST_SCAN) && !pend_reg && !(idx_reg < count_reg);
    assign key_hit    = (state_reg == ST_SCAN) && pend_reg && !is_tick_reg
                        && (rd_key_reg == {it_axis_reg, it_device_reg});
    assign expired    = (state_reg == ST_SCAN) && pend_reg && is_tick_reg
                        && armed_reg[pidx_reg] && (now_reg >= rd_dl_reg);
    assign old_abs    = rd_cur_reg[VALUE_BITS-1] ? (~rd_cur_reg + 1'b1) : rd_cur_reg;
    assign old_not_above = LW'(old_abs[MW-1:0]) <= LW'(cfg.lean_level);
    assign leaned     = LW'(it_mag_reg) >= LW'(cfg.lean_level);
    assign above      = LW'(it_mag_reg) > LW'(cfg.lean_level);

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        pend_next        = pend_reg;
        pidx_next        = pidx_reg;
        count_next       = count_reg;
        now_next         = now_reg;
        armed_next       = armed_reg;
        is_tick_next     = is_tick_reg;
        it_axis_next     = it_axis_reg;
        it_device_next   = it_device_reg;
        it_value_next    = it_value_reg;
        it_mag_next      = it_mag_reg;
        hold_valid_next  = hold_valid_reg;
        hold_axis_next   = hold_axis_reg;
        hold_device_next = hold_device_reg;
        hold_value_next  = hold_value_reg;
        res_valid_next   = 1'b0;
        res_axis_next    = res_axis_reg;
        res_device_next  = res_device_reg;
        res_value_next   = res_value_reg;
        res_bump_next    = res_bump_reg;
        res_rep_next     = res_rep_reg;
        res_last_next    = res_last_reg;
        key_we           = 1'b0;
        cur_we           = 1'b0;
        dl_we            = 1'b0;
        wr_addr          = pidx_reg;
        key_wd           = {it_axis_reg, it_device_reg};
        dl_wd            = hold_dl;
        pop              = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    pop            = 1'b1;
                    idx_next       = '0;
                    pend_next      = 1'b0;
                    it_axis_next   = item_axis;
                    it_device_next = item_device;
                    it_value_next  = item_value;
                    it_mag_next    = item_mag;
                    case (item_op)
                        OP_SAMPLE:
                        begin
                            is_tick_next = 1'b0;
                            state_next   = ST_SCAN;
                        end
                        OP_TICK:
                        begin
                            is_tick_next    = 1'b1;
                            now_next        = sat_add(now_reg, item_elapsed);
                            hold_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            armed_next = '0;
                            count_next = '0;
                            now_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                pend_next = 1'b0;
                if (key_hit)
                begin
                    cur_we = 1'b1;
                    if (leaned)
                    begin
                        if (!armed_reg[pidx_reg])
                        begin
                            armed_next[pidx_reg] = 1'b1;
                            dl_we                = 1'b1;
                        end
                    end
                    else
                    begin
                        armed_next[pidx_reg] = 1'b0;
                    end
                    res_valid_next  = 1'b1;
                    res_axis_next   = it_axis_reg;
                    res_device_next = it_device_reg;
                    res_value_next  = it_value_reg;
                    res_bump_next   = old_not_above && above;
                    res_rep_next    = 1'b0;
                    res_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    if (scan_issue)
                    begin
                        pend_next = 1'b1;
                        pidx_next = idx_reg[AW-1:0];
                        idx_next  = idx_reg + CW'(1);
                    end
                    if (expired)
                    begin
                        dl_we = 1'b1;
                        dl_wd = rep_dl;
                        if (hold_valid_reg)
                        begin
                            res_valid_next  = 1'b1;
                            res_axis_next   = hold_axis_reg;
                            res_device_next = hold_device_reg;
                            res_value_next  = hold_value_reg;
                            res_bump_next   = 1'b1;
                            res_rep_next    = 1'b1;
                            res_last_next   = 1'b0;
                        end
                        hold_valid_next  = 1'b1;
                        hold_axis_next   = rd_key_reg[7:4];
                        hold_device_next = rd_key_reg[3:0];
                        hold_value_next  = rd_cur_reg;
                    end
                    if (scan_done)
                    begin
                        state_next = ST_IDLE;
                        if (is_tick_reg)
                        begin
                            if (hold_valid_reg)
                            begin
                                res_valid_next  = 1'b1;
                                res_axis_next   = hold_axis_reg;
                                res_device_next = hold_device_reg;
                                res_value_next  = hold_value_reg;
                                res_bump_next   = 1'b1;
                                res_rep_next    = 1'b1;
                                res_last_next   = 1'b1;
                            end
                            hold_valid_next = 1'b0;
                        end
                        else
                        begin
                            // key not in table: append if there is room
                            res_valid_next  = 1'b1;
                            res_axis_next   = it_axis_reg;
                            res_device_next = it_device_reg;
                            res_value_next  = it_value_reg;
                            res_rep_next    = 1'b0;
                            res_last_next   = 1'b1;
                            res_bump_next   = 1'b0;
                            if (count_reg < CW'(ENTRIES))
                            begin
                                wr_addr                       = count_reg[AW-1:0];
                                key_we                        = 1'b1;
                                cur_we                        = 1'b1;
                                dl_we                         = 1'b1;
                                armed_next[count_reg[AW-1:0]] = leaned;
                                count_next                    = count_reg + CW'(1);
                                res_bump_next                 = above;
                            end
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            count_reg      <= '0;
            now_reg        <= '0;
            armed_reg      <= '0;
            hold_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            count_reg      <= count_next;
            now_reg        <= now_next;
            armed_reg      <= armed_next;
            hold_valid_reg <= hold_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg        <= pidx_next;
        is_tick_reg     <= is_tick_next;
        it_axis_reg     <= it_axis_next;
        it_device_reg   <= it_device_next;
        it_value_reg    <= it_value_next;
        it_mag_reg      <= it_mag_next;
        hold_axis_reg   <= hold_axis_next;
        hold_device_reg <= hold_device_next;
        hold_value_reg  <= hold_value_next;
        res_axis_reg    <= res_axis_next;
        res_device_reg  <= res_device_next;
        res_value_reg   <= res_value_next;
        res_bump_reg    <= res_bump_next;
        res_rep_reg     <= res_rep_next;
        res_last_reg    <= res_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= key_wd;
        end
        if (cur_we)
        begin
            cur_mem[wr_addr] <= it_value_reg;
        end
        if (dl_we)
        begin
            dl_mem[wr_addr] <= dl_wd;
        end
        if (scan_issue)
        begin
            rd_key_reg <= key_mem[idx_reg[AW-1:0]];
            rd_cur_reg <= cur_mem[idx_reg[AW-1:0]];
            rd_dl_reg  <= dl_mem[idx_reg[AW-1:0]];
        end
    end

    assign result_valid = res_valid_reg;
    assign out_axis     = res_axis_reg;
    assign out_device   = res_device_reg;
    assign out_value    = res_value_reg;
    assign bump         = res_bump_reg;
    assign is_repeat    = res_rep_reg;
    assign last         = res_last_reg;

endmodule

`default_nettype wire

// File: src/axis_event_autorepeat_table_core.sv
// ----------------------------------------------------------------------------
// axis_event_autorepeat_table_core
// Joystick axis conditioner with a keyed auto-repeat table.
// ----------------------------------------------------------------------------
// Requests: start/busy. A request (opcode, axis, device, value, elapsed) is
// taken at a clock edge with start high and busy low; busy is high only while
// the two-entry request queue is full.
// Config: cfg_we/cfg_index/cfg_data, one write per cycle, applied at once.
// Results: one cycle strobe on result_valid with the result fields; last
// marks the final result of a request. The receiver cannot stall.
// Flow, per request, in the table engine: the request is dequeued, then the
// table is walked at one entry per cycle through the registered table read port.
// A sample ends at a hit or, on a miss, at the end of the walk, and its result
// strobe is registered; a tick walks the whole table and its last repeat
// follows the end of the walk. A clear walks nothing and gives no result.
// Reset: table empty, all entries disarmed, time zero, registers at defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_event_autorepeat_table_core #(
    parameter int ENTRIES    = 32,
    parameter int VALUE_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [1:0]                              opcode,
    input  logic [3:0]                              axis,
    input  logic [3:0]                              device,
    input  logic signed [VALUE_BITS-1:0]            value,
    input  logic [15:0]                             elapsed,
    input  logic                                    cfg_we,
    input  logic [aeat_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [aeat_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    output logic                                    result_valid,
    output logic [3:0]                              out_axis,
    output logic [3:0]                              out_device,
    output logic signed [VALUE_BITS-1:0]            out_value,
    output logic                                    bump,
    output logic                                    is_repeat,
    output logic                                    last
);
    import aeat_pkg::*;

    localparam int QW = 2 * VALUE_BITS + 25;

    cfg_t          cfg_reg;
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    logic [QW-1:0] q_wr_data;
    logic [QW-1:0] q_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.invert_mask    <= '0;
            cfg_reg.deadzone_level <= DEADZONE_RESET;
            cfg_reg.lean_level     <= LEAN_RESET;
            cfg_reg.hold_ticks     <= HOLD_RESET;
            cfg_reg.repeat_ticks   <= REPEAT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INVERT_MASK:  cfg_reg.invert_mask    <= cfg_data;
                REG_DEADZONE:     cfg_reg.deadzone_level <= cfg_data[14:0];
                REG_LEAN:         cfg_reg.lean_level     <= cfg_data[14:0];
                REG_HOLD_TICKS:   cfg_reg.hold_ticks     <= cfg_data;
                REG_REPEAT_TICKS: cfg_reg.repeat_ticks   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    aeat_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .cfg        (cfg_reg),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .axis       (axis),
        .device     (device),
        .value      (value),
        .elapsed    (elapsed),
        .queue_full (q_full),
        .push       (q_push),
        .item       (q_wr_data)
    );

    aeat_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    aeat_back #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item_valid   (!q_empty),
        .item         (q_rd_data),
        .pop          (q_pop),
        .result_valid (result_valid),
        .out_axis     (out_axis),
        .out_device   (out_device),
        .out_value    (out_value),
        .bump         (bump),
        .is_repeat    (is_repeat),
        .last         (last)
    );

    // a live sample always closes its request
    a_sample_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !is_repeat |-> last)
        else $error("sample result without last");

    // every repeat carries bump
    a_repeat_bumps: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_repeat |-> bump)
        else $error("repeat result without bump");

    // the engine never dequeues from an empty queue
    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("dequeue from empty request queue");

endmodule

`default_nettype wire
